// ===== src/kcv_pkg.sv =====
// Package for the constant-velocity 2-D Kalman tracker.
// Payload structs, register indexes, sequencer states and shared constants. No dependencies.
package kcv_pkg;

  typedef struct packed {
    logic signed [31:0] meas_dx;
    logic signed [31:0] meas_dy;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] est_dx;
    logic signed [31:0] est_dy;
    logic signed [31:0] est_x;
    logic signed [31:0] est_y;
    logic signed [31:0] est_vx;
    logic signed [31:0] est_vy;
  } out_beat_t;

  typedef enum logic [1:0] {
    RegStepTime     = 2'd0,
    RegProcessNoise = 2'd1,
    RegMeasureNoise = 2'd2
  } reg_idx_e;

  typedef enum logic [3:0] {
    StIdle, StPredX, StPredT, StPredP, StInnov, StDet, StDivGo, StDivWait,
    StGain, StUpdX, StUpdP, StEmit
  } kcv_state_e;

  localparam int unsigned StepTimeW = 21;
  localparam int unsigned NoiseW    = 31;

  localparam logic signed [63:0] Max32 = 64'sd2147483647;
  localparam logic signed [63:0] Min32 = -64'sd2147483648;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > Max32) r = 32'sh7FFFFFFF;
    else if (v < Min32) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

// ===== src/kcv_div.sv =====
// Restoring divider for the innovation inverse: signed 64 / 64, truncating.
// One quotient bit per cycle. Depends on nothing else.
module kcv_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] num_i,
  input  logic signed [63:0] den_i,
  output logic               done_o,
  output logic signed [63:0] quo_o
);
  logic [63:0] rem_q, rem_d, quo_q, quo_d, den_q, den_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, neg_q, neg_d, done_q, done_d;
  logic [64:0] trial;
  logic [63:0] shifted;

  always_comb begin
    rem_d = rem_q; quo_d = quo_q; den_d = den_q; cnt_d = cnt_q;
    busy_d = busy_q; neg_d = neg_q; done_d = 1'b0;
    shifted = {rem_q[62:0], quo_q[63]};
    trial = {1'b0, shifted} - {1'b0, den_q};
    if (start_i) begin
      quo_d = num_i[63] ? 64'(-num_i) : num_i;
      den_d = den_i[63] ? 64'(-den_i) : den_i;
      neg_d = num_i[63] ^ den_i[63];
      rem_d = '0; cnt_d = 7'd64; busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[64]) begin
        rem_d = trial[63:0]; quo_d = {quo_q[62:0], 1'b1};
      end else begin
        rem_d = shifted; quo_d = {quo_q[62:0], 1'b0};
      end
      cnt_d = cnt_q - 7'd1;
      if (cnt_q == 7'd1) begin
        busy_d = 1'b0; done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0; done_q <= 1'b0; cnt_q <= '0;
    end else begin
      busy_q <= busy_d; done_q <= done_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; den_q <= den_d; neg_q <= neg_d;
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? 64'(-quo_q) : quo_q;
endmodule

// ===== src/kalman_cv_2d_tracker.sv =====
// Top level of the constant-velocity 2-D Kalman tracker.
// Uses kcv_pkg and kcv_div.
//
// A sequencer steps one shared 32x32 rounding multiplier through predict, determinant,
// gain and update, one product per cycle, with an innovation step before the
// determinant and an emit step at the end, and the four inverse elements share one
// bit-serial divider. When the innovation determinant is zero, no division runs;
// in_ready_o is high only while idle, so a new input beat is taken only after the
// previous result beat has been emitted.
// A result beat still waiting for out_ready_i stalls only the emit step.
module kalman_cv_2d_tracker #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  kcv_pkg::in_beat_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output kcv_pkg::out_beat_t out_data_o
);
  localparam logic signed [63:0] One  = 64'sd1 <<< FRAC_BITS;
  localparam logic signed [63:0] Half = 64'sd1 <<< (FRAC_BITS - 1);

  logic [kcv_pkg::StepTimeW-1:0] dt_q;
  logic [kcv_pkg::NoiseW-1:0]    qn_q, rn_q;
  logic signed [31:0] x_q [4];
  logic signed [31:0] p_q [16];
  logic signed [31:0] pp_q [16];
  logic signed [31:0] k_q [8];
  logic signed [31:0] si_q [4];
  logic signed [31:0] e_q [2];
  logic signed [31:0] lp_q [2];
  logic signed [63:0] det_q, acc_q;
  kcv_pkg::in_beat_t  in_q;
  kcv_pkg::out_beat_t out_q;
  kcv_pkg::kcv_state_e st_q, st_d;
  logic [5:0] idx_q, idx_d;
  logic out_v_q;
  logic emit_fire;

  // shared rounding multiplier
  logic signed [31:0] ma, mb;
  logic signed [63:0] mp;
  assign mp = ((64'(ma) * 64'(mb)) + Half) >>> FRAC_BITS;

  logic signed [31:0] dts;
  assign dts = $signed({11'd0, dt_q});
  logic signed [63:0] qn_s, rn_s;
  assign qn_s = $signed({33'd0, qn_q});
  assign rn_s = $signed({33'd0, rn_q});

  // APB
  logic wr;
  assign wr = psel && penable && pwrite;
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[3:2])
      kcv_pkg::RegStepTime:     prdata = {11'd0, dt_q};
      kcv_pkg::RegProcessNoise: prdata = {1'b0, qn_q};
      kcv_pkg::RegMeasureNoise: prdata = {1'b0, rn_q};
      default:                  prdata = '0;
    endcase
  end

  // divider
  logic div_start, div_done;
  logic signed [63:0] div_num, div_quo;
  logic signed [31:0] s0, s3;
  assign s0 = kcv_pkg::sat32(64'(pp_q[0]) + rn_s);
  assign s3 = kcv_pkg::sat32(64'(pp_q[5]) + rn_s);
  always_comb begin
    unique case (idx_q[1:0])
      2'd0: div_num = 64'(s3) <<< FRAC_BITS;
      2'd1: div_num = (-64'(pp_q[1])) <<< FRAC_BITS;
      2'd2: div_num = (-64'(pp_q[4])) <<< FRAC_BITS;
      default: div_num = 64'(s0) <<< FRAC_BITS;
    endcase
  end
  assign div_start = (st_q == kcv_pkg::StDivGo);
  kcv_div u_div (.clk_i, .rst_ni, .start_i(div_start), .num_i(div_num),
                 .den_i(det_q), .done_o(div_done), .quo_o(div_quo));

  logic [1:0] ri, ci;
  assign ri = idx_q[3:2];
  assign ci = idx_q[1:0];

  logic signed [63:0] det_new, pp_sum;
  assign det_new = acc_q - mp;

  always_comb begin
    pp_sum = 64'(p_q[idx_q[3:0]]);
    if (!ci[1]) pp_sum = pp_sum + mp;
    if (ri == ci) pp_sum = pp_sum + qn_s;
  end

  // next state
  always_comb begin
    st_d = st_q;
    idx_d = idx_q;
    unique case (st_q)
      kcv_pkg::StIdle: begin
        idx_d = '0;
        if (in_valid_i) st_d = kcv_pkg::StPredX;
      end
      kcv_pkg::StPredX: begin
        idx_d = idx_q + 6'd1;
        if (idx_q == 6'd1) begin st_d = kcv_pkg::StPredT; idx_d = '0; end
      end
      kcv_pkg::StPredT: begin
        idx_d = idx_q + 6'd1;
        if (idx_q == 6'd7) begin st_d = kcv_pkg::StPredP; idx_d = '0; end
      end
      kcv_pkg::StPredP: begin
        idx_d = idx_q + 6'd1;
        if (idx_q == 6'd15) begin st_d = kcv_pkg::StInnov; idx_d = '0; end
      end
      kcv_pkg::StInnov: begin
        st_d = kcv_pkg::StDet; idx_d = '0;
      end
      kcv_pkg::StDet: begin
        idx_d = idx_q + 6'd1;
        if (idx_q[0]) begin
          idx_d = '0;
          st_d = (det_new == 64'sd0) ? kcv_pkg::StGain : kcv_pkg::StDivGo;
        end
      end
      kcv_pkg::StDivGo: st_d = kcv_pkg::StDivWait;
      kcv_pkg::StDivWait: begin
        if (div_done) begin
          if (idx_q == 6'd3) begin
            st_d = kcv_pkg::StGain; idx_d = '0;
          end else begin
            st_d = kcv_pkg::StDivGo; idx_d = idx_q + 6'd1;
          end
        end
      end
      kcv_pkg::StGain: begin
        idx_d = idx_q + 6'd1;
        if (idx_q == 6'd15) begin st_d = kcv_pkg::StUpdX; idx_d = '0; end
      end
      kcv_pkg::StUpdX: begin
        idx_d = idx_q + 6'd1;
        if (idx_q == 6'd7) begin st_d = kcv_pkg::StUpdP; idx_d = '0; end
      end
      kcv_pkg::StUpdP: begin
        idx_d = idx_q + 6'd1;
        if (idx_q == 6'd31) begin st_d = kcv_pkg::StEmit; idx_d = '0; end
      end
      kcv_pkg::StEmit: if (!out_v_q || out_ready_i) st_d = kcv_pkg::StIdle;
      default: st_d = kcv_pkg::StIdle;
    endcase
  end

  // outputs and multiplier operand select
  assign in_ready_o = (st_q == kcv_pkg::StIdle);
  assign emit_fire  = (st_q == kcv_pkg::StEmit) && (!out_v_q || out_ready_i);

  always_comb begin
    ma = '0; mb = '0;
    unique case (st_q)
      kcv_pkg::StPredX: begin ma = dts; mb = x_q[{1'b1, idx_q[0]}]; end
      kcv_pkg::StPredT: begin ma = dts; mb = p_q[{1'b1, idx_q[2:0]}]; end
      kcv_pkg::StPredP: begin ma = pp_q[0] ^ pp_q[0] ^ p_q[{ri, 1'b1, ci[0]}]; mb = dts; end
      kcv_pkg::StDet: begin
        if (!idx_q[0]) begin ma = s0; mb = s3; end
        else begin ma = pp_q[1]; mb = pp_q[4]; end
      end
      kcv_pkg::StGain: begin
        ma = pp_q[{idx_q[3:2], 1'b0, idx_q[0]}];
        mb = si_q[{idx_q[0], idx_q[1]}];
      end
      kcv_pkg::StUpdX: begin
        ma = k_q[{idx_q[2:1], idx_q[0]}];
        mb = e_q[idx_q[0]];
      end
      kcv_pkg::StUpdP: begin
        ma = k_q[{idx_q[4:3], idx_q[0]}];
        mb = pp_q[{1'b0, idx_q[0], idx_q[2:1]}];
      end
      default: ;
    endcase
  end

  // working values without reset
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      kcv_pkg::StIdle: if (in_valid_i) in_q <= in_data_i;
      kcv_pkg::StPredP: pp_q[idx_q[3:0]] <= kcv_pkg::sat32(pp_sum);
      kcv_pkg::StInnov: begin
        e_q[0] <= kcv_pkg::sat32(64'(kcv_pkg::sat32(64'(lp_q[0]) + 64'(in_q.meas_dx)))
                  - 64'(x_q[0]));
        e_q[1] <= kcv_pkg::sat32(64'(kcv_pkg::sat32(64'(lp_q[1]) + 64'(in_q.meas_dy)))
                  - 64'(x_q[1]));
      end
      kcv_pkg::StDet: begin
        if (!idx_q[0]) begin
          acc_q <= mp;
        end else begin
          det_q <= det_new;
          for (int i = 0; i < 4; i++) si_q[i] <= '0;
        end
      end
      kcv_pkg::StDivWait: if (div_done) si_q[idx_q[1:0]] <= kcv_pkg::sat32(div_quo);
      kcv_pkg::StGain: begin
        if (!idx_q[0]) acc_q <= mp;
        else k_q[idx_q[3:1]] <= kcv_pkg::sat32(acc_q + mp);
      end
      kcv_pkg::StUpdX: if (!idx_q[0]) acc_q <= 64'(x_q[idx_q[2:1]]) + mp;
      kcv_pkg::StUpdP: if (!idx_q[0]) acc_q <= 64'(pp_q[idx_q[4:1]]) - mp;
      kcv_pkg::StEmit: begin
        if (emit_fire) begin
          out_q.est_dx <= kcv_pkg::sat32(64'(x_q[0]) - 64'(lp_q[0]));
          out_q.est_dy <= kcv_pkg::sat32(64'(x_q[1]) - 64'(lp_q[1]));
          out_q.est_x  <= x_q[0];
          out_q.est_y  <= x_q[1];
          out_q.est_vx <= x_q[2];
          out_q.est_vy <= x_q[3];
        end
      end
      default: ;
    endcase
  end

  // state, registers and filter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= kcv_pkg::StIdle; idx_q <= '0; out_v_q <= 1'b0;
      dt_q <= 21'(One); qn_q <= 31'(One); rn_q <= 31'((One + 64'sd5) / 10);
      for (int i = 0; i < 4; i++) x_q[i] <= '0;
      for (int i = 0; i < 16; i++) p_q[i] <= (i % 5 == 0) ? 32'(One) : '0;
      lp_q[0] <= '0; lp_q[1] <= '0;
    end else begin
      st_q <= st_d; idx_q <= idx_d;
      if (emit_fire) out_v_q <= 1'b1;
      else if (out_ready_i) out_v_q <= 1'b0;
      if (emit_fire) begin
        lp_q[0] <= x_q[0]; lp_q[1] <= x_q[1];
      end
      if (wr) begin
        unique case (paddr[3:2])
          kcv_pkg::RegStepTime:     dt_q <= pwdata[20:0];
          kcv_pkg::RegProcessNoise: qn_q <= pwdata[30:0];
          kcv_pkg::RegMeasureNoise: rn_q <= pwdata[30:0];
          default: ;
        endcase
      end
      unique case (st_q)
        kcv_pkg::StPredX:
          x_q[{1'b0, idx_q[0]}] <= kcv_pkg::sat32(64'(x_q[{1'b0, idx_q[0]}]) + mp);
        kcv_pkg::StPredT:
          p_q[{1'b0, idx_q[2:0]}] <= kcv_pkg::sat32(64'(p_q[{1'b0, idx_q[2:0]}]) + mp);
        kcv_pkg::StUpdX: if (idx_q[0]) x_q[idx_q[2:1]] <= kcv_pkg::sat32(acc_q + mp);
        kcv_pkg::StUpdP: if (idx_q[0]) p_q[idx_q[4:1]] <= kcv_pkg::sat32(acc_q - mp);
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != kcv_pkg::StIdle) |-> !in_ready_o) else $error("ready while busy");
  a_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (st_q == kcv_pkg::StDivWait)) else $error("stray divider done");
  a_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("result beat dropped or changed");
  a_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == kcv_pkg::StIdle) |-> (idx_q == 6'd0)) else $error("index not cleared");
endmodule
